### design/tgmc_pkg.sv
// Shared types and constants for the triangle curvature block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package tgmc_pkg;

    localparam int unsigned DET_B_W = 65;   // det(b), signed Q32.32
    localparam int unsigned HNUM_W  = 100;  // mean-curvature numerator, signed Q48.48
    localparam int unsigned DEN_W   = 128;  // det(a), unsigned Q64.64
    localparam int unsigned REM_W   = 160;  // divider partial remainder
    localparam int unsigned Q_W     = 32;   // quotient bits produced by the divider
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // One triangle after the front end: the shared divisor and both numerators.
    typedef struct packed {
        logic                      singular;
        logic [DEN_W-1:0]          den;
        logic signed [DET_B_W-1:0] det_b;
        logic signed [HNUM_W-1:0]  hnum;
    } t_job;

    // Queue status seen by the front and back ends.
    typedef struct packed {
        logic nonempty;
        logic full;
    } t_q_status;

endpackage

### design/tgmc_front.sv
// Front end: multiplier pipeline that forms det(a), det(b) and the mean-curvature numerator.
// Depends on tgmc_pkg.
module tgmc_front import tgmc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_x_du,
    input  logic signed [31:0] i_x_dv,
    input  logic signed [31:0] i_y_du,
    input  logic signed [31:0] i_y_dv,
    input  logic signed [31:0] i_z_du,
    input  logic signed [31:0] i_z_dv,
    input  logic signed [31:0] i_form_uu,
    input  logic signed [31:0] i_form_uv,
    input  logic signed [31:0] i_form_vv,
    output logic               o_valid,
    output t_job               o_job
);

    logic [4:0] r_vld;

    // Stage 1: 32x32 products.
    logic signed [63:0] r1_xuu, r1_yuu, r1_zuu, r1_xvv, r1_yvv, r1_zvv;
    logic signed [63:0] r1_xuv, r1_yuv, r1_zuv, r1_b1122, r1_b12sq;
    logic signed [31:0] r1_b11, r1_b12, r1_b22;

    // Stage 2: metric entries and det(b).
    logic [63:0]               r2_a11, r2_a22;
    logic signed [64:0]        r2_a12;
    logic signed [DET_B_W-1:0] r2_det_b;
    logic signed [31:0]        r2_b11, r2_b12, r2_b22;
    logic signed [65:0]        n2_a11, n2_a22;

    // Stage 3: partial products of the wide multiplications.
    logic [63:0]               r3_aa00, r3_aa01, r3_aa10, r3_aa11, r3_mm00;
    logic signed [65:0]        r3_mm01, r3_mm11;
    logic signed [64:0]        r3_ab0, r3_ab1, r3_hb0, r3_hb1, r3_cb0, r3_cb1;
    logic signed [DET_B_W-1:0] r3_det_b;

    // Stage 4: a11*a22, a12^2 and the numerator.
    logic [DEN_W-1:0]          r4_aa, r4_mm, n4_aa;
    logic [129:0]              n4_mm;
    logic signed [HNUM_W-1:0]  r4_hnum, n4_hnum;
    logic signed [DET_B_W-1:0] r4_det_b;

    // Stage 5: det(a) and the singular decision.
    logic [DEN_W:0] n5_det;
    t_job           r5_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_comb begin
        n2_a11 = 66'(r1_xuu) + 66'(r1_yuu) + 66'(r1_zuu);
        n2_a22 = 66'(r1_xvv) + 66'(r1_yvv) + 66'(r1_zvv);
        n4_aa  = {r3_aa11, 64'd0} + ({64'd0, r3_aa01} << 32) + ({64'd0, r3_aa10} << 32)
               + {64'd0, r3_aa00};
        n4_mm  = (130'(r3_mm11) << 64) + (130'(r3_mm01) << 33) + 130'(r3_mm00);
        n4_hnum = (HNUM_W'(r3_ab1) << 32) + HNUM_W'(r3_ab0)
                - (((HNUM_W'(r3_hb1) << 32) + HNUM_W'(r3_hb0)) << 1)
                + (HNUM_W'(r3_cb1) << 32) + HNUM_W'(r3_cb0);
        n5_det = {1'b0, r4_aa} - {1'b0, r4_mm};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_xuu   <= i_x_du * i_x_du;
            r1_yuu   <= i_y_du * i_y_du;
            r1_zuu   <= i_z_du * i_z_du;
            r1_xvv   <= i_x_dv * i_x_dv;
            r1_yvv   <= i_y_dv * i_y_dv;
            r1_zvv   <= i_z_dv * i_z_dv;
            r1_xuv   <= i_x_du * i_x_dv;
            r1_yuv   <= i_y_du * i_y_dv;
            r1_zuv   <= i_z_du * i_z_dv;
            r1_b1122 <= i_form_uu * i_form_vv;
            r1_b12sq <= i_form_uv * i_form_uv;
            r1_b11   <= i_form_uu;
            r1_b12   <= i_form_uv;
            r1_b22   <= i_form_vv;

            r2_a11   <= n2_a11[63:0];
            r2_a22   <= n2_a22[63:0];
            r2_a12   <= 65'(r1_xuv) + 65'(r1_yuv) + 65'(r1_zuv);
            r2_det_b <= 65'(r1_b1122) - 65'(r1_b12sq);
            r2_b11   <= r1_b11;
            r2_b12   <= r1_b12;
            r2_b22   <= r1_b22;

            // a12 is split as a signed high half and an unsigned low half.
            r3_aa00  <= r2_a11[31:0] * r2_a22[31:0];
            r3_aa01  <= r2_a11[31:0] * r2_a22[63:32];
            r3_aa10  <= r2_a11[63:32] * r2_a22[31:0];
            r3_aa11  <= r2_a11[63:32] * r2_a22[63:32];
            r3_mm00  <= r2_a12[31:0] * r2_a12[31:0];
            r3_mm01  <= $signed(r2_a12[64:32]) * $signed({1'b0, r2_a12[31:0]});
            r3_mm11  <= $signed(r2_a12[64:32]) * $signed(r2_a12[64:32]);
            r3_ab0   <= $signed({1'b0, r2_a11[31:0]}) * r2_b22;
            r3_ab1   <= $signed({1'b0, r2_a11[63:32]}) * r2_b22;
            r3_hb0   <= $signed({1'b0, r2_a12[31:0]}) * r2_b12;
            r3_hb1   <= $signed(r2_a12[64:32]) * r2_b12;
            r3_cb0   <= $signed({1'b0, r2_a22[31:0]}) * r2_b11;
            r3_cb1   <= $signed({1'b0, r2_a22[63:32]}) * r2_b11;
            r3_det_b <= r2_det_b;

            r4_aa    <= n4_aa;
            r4_mm    <= n4_mm[DEN_W-1:0];
            r4_hnum  <= n4_hnum;
            r4_det_b <= r3_det_b;

            r5_job.singular <= n5_det[DEN_W] | (n5_det == '0);
            r5_job.den      <= n5_det[DEN_W-1:0];
            r5_job.det_b    <= r4_det_b;
            r5_job.hnum     <= r4_hnum;
        end
    end

    assign o_valid = r_vld[4];
    assign o_job   = r5_job;

endmodule

### design/tgmc_queue.sv
// Short register queue between the front and back ends.
// Depends on tgmc_pkg.
module tgmc_queue import tgmc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_q_status o_status,
    output t_job      o_job
);

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + FIFO_CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - FIFO_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_status.nonempty = (r_cnt != '0);
    assign o_status.full     = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_job             = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_cnt == FIFO_CW'(FIFO_DEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_cnt == '0))
        else $error("queue read while empty");

endmodule

### design/tgmc_back.sv
// Back end: two lanes of a pipelined restoring divider sharing det(a), then rounding and clipping.
// Depends on tgmc_pkg.
module tgmc_back import tgmc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_job               i_job,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [31:0] o_gauss_curvature,
    output logic signed [31:0] o_mean_curvature,
    output logic               o_singular,
    output logic               o_saturated
);

    localparam int unsigned NSTG = Q_W + 3;

    logic            en;
    logic [NSTG-1:0] r_vld;

    // Stage 0: magnitudes of the scaled numerators.
    logic [REM_W-1:0] r0_rk, r0_rh;
    logic [DEN_W-1:0] r0_den;
    logic             r0_nk, r0_nh, r0_sing;
    logic [DET_B_W-1:0] n0_mk;
    logic [HNUM_W-1:0]  n0_mh;

    // Divider chain, index 0 written by the range check stage.
    logic [REM_W-1:0] r_rk  [Q_W+1];
    logic [REM_W-1:0] r_rh  [Q_W+1];
    logic [Q_W-1:0]   r_qk  [Q_W+1];
    logic [Q_W-1:0]   r_qh  [Q_W+1];
    logic [DEN_W-1:0] r_den [Q_W+1];
    logic             r_nk  [Q_W+1];
    logic             r_nh  [Q_W+1];
    logic             r_ok  [Q_W+1];
    logic             r_oh  [Q_W+1];
    logic             r_sg  [Q_W+1];

    logic signed [31:0] r_k, r_h;
    logic               r_sing, r_sat;
    logic [32:0]        n_k, n_h;

    // Rounds, signs and clips one quotient; bit 32 of the result flags a clip.
    function automatic logic [32:0] finish(input logic [Q_W-1:0] q, input logic [REM_W-1:0] rem,
                                           input logic [DEN_W-1:0] den, input logic neg,
                                           input logic over);
        logic        rnd;
        logic [32:0] q33, lim;
        logic        clip;
        rnd  = ({rem[DEN_W-1:0], 1'b0} >= {1'b0, den});
        q33  = {1'b0, q} + 33'(rnd);
        lim  = 33'h07FFF_FFFF + 33'(neg);
        clip = over | (q33 > lim);
        if (clip) begin
            finish = {1'b1, (neg ? 32'h8000_0000 : 32'h7FFF_FFFF)};
        end else begin
            finish = {1'b0, (neg ? 32'(-q33) : q33[31:0])};
        end
    endfunction

    assign en    = !r_vld[NSTG-1] || !i_stall;
    assign o_pop = en && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_comb begin
        n0_mk = i_job.det_b[DET_B_W-1] ? DET_B_W'(-i_job.det_b) : DET_B_W'(i_job.det_b);
        n0_mh = i_job.hnum[HNUM_W-1] ? HNUM_W'(-i_job.hnum) : HNUM_W'(i_job.hnum);
        n_k   = finish(r_qk[Q_W], r_rk[Q_W], r_den[Q_W], r_nk[Q_W], r_ok[Q_W]);
        n_h   = finish(r_qh[Q_W], r_rh[Q_W], r_den[Q_W], r_nh[Q_W], r_oh[Q_W]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // det(b) scaled by 2^48, numerator of H by 2^31.
            r0_rk   <= REM_W'(n0_mk) << 48;
            r0_rh   <= REM_W'(n0_mh) << 31;
            r0_den  <= i_job.den;
            r0_nk   <= i_job.det_b[DET_B_W-1];
            r0_nh   <= i_job.hnum[HNUM_W-1];
            r0_sing <= i_job.singular;

            // A quotient of 2^32 or more clips in any case.
            r_rk[0]  <= r0_rk;
            r_rh[0]  <= r0_rh;
            r_qk[0]  <= '0;
            r_qh[0]  <= '0;
            r_den[0] <= r0_den;
            r_nk[0]  <= r0_nk;
            r_nh[0]  <= r0_nh;
            r_ok[0]  <= (r0_rk >= {r0_den, 32'd0});
            r_oh[0]  <= (r0_rh >= {r0_den, 32'd0});
            r_sg[0]  <= r0_sing;

            r_k    <= r_sg[Q_W] ? 32'sd0 : $signed(n_k[31:0]);
            r_h    <= r_sg[Q_W] ? 32'sd0 : $signed(n_h[31:0]);
            r_sing <= r_sg[Q_W];
            r_sat  <= !r_sg[Q_W] && (n_k[32] || n_h[32]);
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 0; s < Q_W; s++) begin : g_div
        localparam int unsigned BIT = Q_W - 1 - s;
        logic [REM_W-1:0] dsh;
        logic             tk, th;
        assign dsh = {{(REM_W-DEN_W){1'b0}}, r_den[s]} << BIT;
        assign tk  = (r_rk[s] >= dsh);
        assign th  = (r_rh[s] >= dsh);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rk[s+1]  <= tk ? (r_rk[s] - dsh) : r_rk[s];
                r_rh[s+1]  <= th ? (r_rh[s] - dsh) : r_rh[s];
                r_qk[s+1]  <= r_qk[s] | (Q_W'(tk) << BIT);
                r_qh[s+1]  <= r_qh[s] | (Q_W'(th) << BIT);
                r_den[s+1] <= r_den[s];
                r_nk[s+1]  <= r_nk[s];
                r_nh[s+1]  <= r_nh[s];
                r_ok[s+1]  <= r_ok[s];
                r_oh[s+1]  <= r_oh[s];
                r_sg[s+1]  <= r_sg[s];
            end
        end
    end

    assign o_valid           = r_vld[NSTG-1];
    assign o_gauss_curvature = r_k;
    assign o_mean_curvature  = r_h;
    assign o_singular        = r_sing;
    assign o_saturated       = r_sat;

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (r_k == 0 && r_h == 0 && !r_sat))
        else $error("singular result carries nonzero curvature");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (r_k == 32'sh7FFF_FFFF || r_k == 32'sh8000_0000 ||
                                      r_h == 32'sh7FFF_FFFF || r_h == 32'sh8000_0000))
        else $error("saturated flag without a clipped result");

endmodule

### design/triangle_gauss_mean_curvature.sv
// Top level of the triangle curvature block: front end, queue and back end.
// Depends on tgmc_pkg, tgmc_front, tgmc_queue and tgmc_back.
//
// Each input transfer carries one triangle: the six entries of its 3x2
// deformation gradient and the three entries of its second fundamental form,
// all signed Q16.16. Each triangle gives exactly one output transfer with the
// Gauss and mean curvature in signed Q16.16, a singular flag (the metric
// determinant is not positive; both curvatures are then zero) and a saturated
// flag (a curvature was clipped to the 32-bit range).
// Both channels use valid and stall; a transfer happens on a rising edge with
// valid high and stall low. The block takes one triangle per cycle while
// o_stall is low. The result of a triangle passes five multiply and add
// stages, the queue and 35 back-end stages, 41 registers in all, the first
// of them loaded on the input transfer edge itself. Most of the back end is
// the 32-stage quotient pipeline that delivers one bit per stage.
// When the receiver stalls, the back end holds, the four-entry queue fills,
// and then the front end holds and raises o_stall. Reset empties all stages
// and the queue; no results are pending after it.
module triangle_gauss_mean_curvature import tgmc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_x_du,
    input  logic signed [31:0] i_x_dv,
    input  logic signed [31:0] i_y_du,
    input  logic signed [31:0] i_y_dv,
    input  logic signed [31:0] i_z_du,
    input  logic signed [31:0] i_z_dv,
    input  logic signed [31:0] i_form_uu,
    input  logic signed [31:0] i_form_uv,
    input  logic signed [31:0] i_form_vv,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_gauss_curvature,
    output logic signed [31:0] o_mean_curvature,
    output logic               o_singular,
    output logic               o_saturated
);

    logic      front_en, front_valid, push, pop;
    t_job      front_job, queue_job;
    t_q_status q_status;

    // The front end only holds when its finished item cannot enter the queue.
    assign front_en = !front_valid || !q_status.full;
    assign push     = front_valid && !q_status.full;
    assign o_stall  = !front_en;

    tgmc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (front_en),
        .i_valid   (i_valid),
        .i_x_du    (i_x_du),
        .i_x_dv    (i_x_dv),
        .i_y_du    (i_y_du),
        .i_y_dv    (i_y_dv),
        .i_z_du    (i_z_du),
        .i_z_dv    (i_z_dv),
        .i_form_uu (i_form_uu),
        .i_form_uv (i_form_uv),
        .i_form_vv (i_form_vv),
        .o_valid   (front_valid),
        .o_job     (front_job)
    );

    tgmc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (front_job),
        .i_pop    (pop),
        .o_status (q_status),
        .o_job    (queue_job)
    );

    tgmc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (q_status.nonempty),
        .i_job             (queue_job),
        .o_pop             (pop),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_gauss_curvature (o_gauss_curvature),
        .o_mean_curvature  (o_mean_curvature),
        .o_singular        (o_singular),
        .o_saturated       (o_saturated)
    );

endmodule

### bench/triangle_gauss_mean_curvature_test.sv
// Self-checking bench for the triangle curvature block (triangle_gauss_mean_curvature).
// Depends on tgmc_pkg and the block's RTL; predicts each result with wide exact arithmetic.
module triangle_gauss_mean_curvature_test;

    // One triangle as it is offered on the input channel.
    typedef struct {
        logic signed [31:0] xu, xv, yu, yv, zu, zv, buu, buv, bvv;
        bit                 drain_after;  // sender waits for all results after this one
    } t_tri;

    // One expected curvature result.
    typedef struct {
        logic signed [31:0] gauss;
        logic signed [31:0] mean;
        logic               sing;
        logic               sat;
    } t_curv;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 60;

    logic               i_clk, i_rst_n, i_valid, i_stall;
    logic               o_stall, o_valid, o_singular, o_saturated;
    logic signed [31:0] i_x_du, i_x_dv, i_y_du, i_y_dv, i_z_du, i_z_dv;
    logic signed [31:0] i_form_uu, i_form_uv, i_form_vv;
    logic signed [31:0] o_gauss_curvature, o_mean_curvature;

    t_tri  pending_tris[$];
    t_curv expected_curv[$];
    int    fail_count = 0;
    int    sent_count = 0;
    int    got_count = 0;
    int    sing_seen = 0;
    int    sat_seen = 0;
    int    idle_cycles = 0;
    bit    stim_done = 0;
    bit    hold_long = 0;
    bit    draining = 0;

    triangle_gauss_mean_curvature u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_x_du(i_x_du), .i_x_dv(i_x_dv), .i_y_du(i_y_du), .i_y_dv(i_y_dv),
        .i_z_du(i_z_du), .i_z_dv(i_z_dv), .i_form_uu(i_form_uu),
        .i_form_uv(i_form_uv), .i_form_vv(i_form_vv), .o_valid(o_valid),
        .i_stall(i_stall), .o_gauss_curvature(o_gauss_curvature),
        .o_mean_curvature(o_mean_curvature), .o_singular(o_singular),
        .o_saturated(o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Rounded signed quotient (ties away from zero), clipped to 32 bits.
    // The denominator is always positive here.
    function automatic logic signed [31:0] div_round_clip(input logic signed [255:0] num,
                                                          input logic signed [255:0] den,
                                                          inout logic clipped);
        logic        [255:0] mag;
        logic        [255:0] q;
        logic        [255:0] r;
        logic                neg;
        neg = num[255];
        mag = neg ? -num : num;
        q = mag / den;
        r = mag % den;
        if ((r << 1) >= den) q = q + 1;
        if (!neg && q > 256'h7FFF_FFFF) begin
            clipped = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (neg && q > 256'h8000_0000) begin
            clipped = 1'b1;
            return 32'sh8000_0000;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    // Metric from F, then K and H each with a single rounding.
    function automatic t_curv predict_curvature(input t_tri t);
        logic signed [255:0] xu, xv, yu, yv, zu, zv, b11, b12, b22;
        logic signed [255:0] a11, a12, a22, det_a, det_b, hnum;
        t_curv               res;
        logic                clip;
        xu = t.xu; xv = t.xv; yu = t.yu; yv = t.yv; zu = t.zu; zv = t.zv;
        b11 = t.buu; b12 = t.buv; b22 = t.bvv;
        a11 = xu * xu + yu * yu + zu * zu;
        a12 = xu * xv + yu * yv + zu * zv;
        a22 = xv * xv + yv * yv + zv * zv;
        det_a = a11 * a22 - a12 * a12;
        clip = 1'b0;
        if (det_a <= 0) begin
            res.gauss = '0;
            res.mean = '0;
            res.sing = 1'b1;
            res.sat = 1'b0;
            return res;
        end
        det_b = b11 * b22 - b12 * b12;
        hnum = a11 * b22 - ((a12 * b12) <<< 1) + a22 * b11;
        res.gauss = div_round_clip(det_b <<< 48, det_a, clip);
        res.mean = div_round_clip(hnum <<< 31, det_a, clip);
        res.sing = 1'b0;
        res.sat = clip;
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random Q16.16 value of a chosen magnitude class.
    function automatic logic signed [31:0] rand_fix(input int kind);
        logic signed [31:0] v;
        case (kind)
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            2: v = $signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200;
            default: begin
                v = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            end
        endcase
        return v;
    endfunction

    function automatic t_tri make_tri(input logic signed [31:0] xu, xv, yu, yv, zu, zv,
                                      input logic signed [31:0] buu, buv, bvv);
        t_tri t;
        t.xu = xu; t.xv = xv; t.yu = yu; t.yv = yv; t.zu = zu; t.zv = zv;
        t.buu = buu; t.buv = buv; t.bvv = bvv;
        t.drain_after = 1'b0;
        return t;
    endfunction

    // Stimulus: directed corners first, then random triangles.
    initial begin
        t_tri t;
        int   kind_f;
        int   kind_b;
        int   n;
        localparam logic signed [31:0] ONE = 32'sh0001_0000;
        localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
        localparam logic signed [31:0] MINV = 32'sh8000_0000;
        // Flat unit patch, unit sphere-like form, and a saddle.
        pending_tris.push_back(make_tri(ONE, 0, 0, ONE, 0, 0, 0, 0, 0));
        pending_tris.push_back(make_tri(ONE, 0, 0, ONE, 0, 0, ONE, 0, ONE));
        pending_tris.push_back(make_tri(ONE, 0, 0, ONE, 0, 0, ONE, 0, -ONE));
        // All zero: singular metric.
        pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, ONE, ONE, ONE));
        // Parallel columns: determinant exactly zero.
        pending_tris.push_back(make_tri(ONE, 2 * ONE, ONE, 2 * ONE, 0, 0, ONE, 0, ONE));
        // Tiny metric with large form: at least one result clips in each.
        pending_tris.push_back(make_tri(1, 0, 0, 1, 0, 0, MAXV, 0, MAXV));
        pending_tris.push_back(make_tri(1, 0, 0, 1, 0, 0, MINV, 0, MAXV));
        pending_tris.push_back(make_tri(1, 0, 0, 1, 0, 0, MINV, MINV, MINV));
        // Field extremes throughout.
        pending_tris.push_back(make_tri(MAXV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV));
        pending_tris.push_back(make_tri(MINV, 0, 0, MINV, 0, 0, MINV, MAXV, MINV));
        pending_tris.push_back(make_tri(MAXV, 0, 0, MAXV, MINV, MINV, -1, -1, -1));
        pending_tris.push_back(make_tri(-1, 1, 1, -1, -1, -1, -1, 1, -1));
        // Rounding tie region: half-unit quotients.
        pending_tris.push_back(make_tri(2 * ONE, 0, 0, ONE, 0, 0, 1, 0, 1));
        pending_tris.push_back(make_tri(2 * ONE, 0, 0, ONE, 0, 0, -1, 0, 1));
        pending_tris.push_back(make_tri(ONE, 0, 0, ONE, 0, 0, 3, 1, -3));
        t = make_tri(ONE, ONE, 0, ONE, ONE, 0, -ONE, ONE / 2, 2 * ONE);
        t.drain_after = 1'b1;
        pending_tris.push_back(t);
        for (n = 0; n < 1950; n++) begin
            kind_f = $urandom_range(0, 9);
            kind_f = (kind_f < 3) ? 0 : (kind_f < 8) ? 1 : (kind_f < 9) ? 2 : 3;
            kind_b = $urandom_range(0, 3);
            t = make_tri(rand_fix(kind_f), rand_fix(kind_f), rand_fix(kind_f),
                         rand_fix(kind_f), rand_fix(kind_f), rand_fix(kind_f),
                         rand_fix(kind_b), rand_fix(kind_b), rand_fix(kind_b));
            // Some triangles get parallel columns to hit the singular path.
            if ($urandom_range(0, 19) == 0) begin
                t.xv = t.xu; t.yv = t.yu; t.zv = t.zu;
            end
            t.drain_after = (n == 900);
            pending_tris.push_back(t);
        end
        stim_done = 1'b1;
    end

    // Driver: offers the queued triangles with random gaps.
    int send_gap = 0;
    always @(posedge i_clk) begin
        t_tri t;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
            draining <= 1'b0;
        end else begin
            if (i_valid && !o_stall) sent_count <= sent_count + 1;
            if (i_valid && o_stall) begin
                // Payload must hold while stalled.
            end else if (draining) begin
                i_valid <= 1'b0;
                if (expected_curv.size() == 0 && !(i_valid && !o_stall)) draining <= 1'b0;
            end else if (send_gap > 0) begin
                i_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_tris.size() > 0) begin
                t = pending_tris.pop_front();
                i_valid <= 1'b1;
                i_x_du <= t.xu; i_x_dv <= t.xv; i_y_du <= t.yu; i_y_dv <= t.yv;
                i_z_du <= t.zu; i_z_dv <= t.zv;
                i_form_uu <= t.buu; i_form_uv <= t.buv; i_form_vv <= t.bvv;
                expected_curv.push_back(predict_curvature(t));
                if (t.drain_after) draining <= 1'b1;
                else send_gap <= pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random, with one long hold-off early in the random part.
    int stall_left = 0;
    int long_hold_count = 0;
    bit long_hold_done = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (!long_hold_done && sent_count > 300) begin
            if (long_hold_count < 200) begin
                i_stall <= 1'b1;
                long_hold_count <= long_hold_count + 1;
            end else begin
                i_stall <= 1'b0;
                long_hold_done <= 1'b1;
            end
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall <= 1'b0;
            // Stretches of no stalling between the middle items.
            if (!(sent_count > 1200 && sent_count < 1400)) stall_left <= pick_gap();
        end
    end

    // Monitor: checks each output transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_curv exp_c;
        int    errs;
        errs = 0;
        if (i_rst_n && o_valid && !i_stall) begin
            got_count <= got_count + 1;
            if (expected_curv.size() == 0) begin
                $display("%0t: unexpected result K=%h H=%h", $time,
                         o_gauss_curvature, o_mean_curvature);
                errs = errs + 1;
            end else begin
                exp_c = expected_curv.pop_front();
                if (exp_c.sing) sing_seen <= sing_seen + 1;
                if (exp_c.sat) sat_seen <= sat_seen + 1;
                if (o_gauss_curvature !== exp_c.gauss) begin
                    $display("%0t: gauss expected %h actual %h", $time,
                             exp_c.gauss, o_gauss_curvature);
                    errs = errs + 1;
                end
                if (o_mean_curvature !== exp_c.mean) begin
                    $display("%0t: mean expected %h actual %h", $time,
                             exp_c.mean, o_mean_curvature);
                    errs = errs + 1;
                end
                if (o_singular !== exp_c.sing) begin
                    $display("%0t: singular expected %b actual %b", $time,
                             exp_c.sing, o_singular);
                    errs = errs + 1;
                end
                if (o_saturated !== exp_c.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             exp_c.sat, o_saturated);
                    errs = errs + 1;
                end
            end
        end
        if (errs != 0) fail_count <= fail_count + errs;
    end

    // Watchdog: counts cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Reset, then wait for the stimulus to drain and report.
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        {i_x_du, i_x_dv, i_y_du, i_y_dv, i_z_du, i_z_dv} = '0;
        {i_form_uu, i_form_uv, i_form_vv} = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && pending_tris.size() == 0 && !i_valid);
        wait (expected_curv.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_curv.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_curv.size());
            fail_count = fail_count + 1;
        end
        $display("Checked %0d triangles, %0d results, %0d singular, %0d clipped.",
                 sent_count, got_count, sing_seen, sat_seen);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
